[design/pdrb_pkg.sv]
package pdrb_pkg;

   // Object kind, raw bits 31:30
   localparam logic [1:0] KIND_FIXED    = 2'd0;
   localparam logic [1:0] KIND_BATTERY  = 2'd1;
   localparam logic [1:0] KIND_VARIABLE = 2'd2;
   localparam logic [1:0] KIND_AUG      = 2'd3;

   // Augmented subtype, raw bits 29:28
   localparam logic [1:0] SUB_PPS      = 2'd0;
   localparam logic [1:0] SUB_EPR_AVS  = 2'd1;
   localparam logic [1:0] SUB_SPR_AVS  = 2'd2;
   localparam logic [1:0] SUB_RESERVED = 2'd3;

   // Request bits 25:24 set on every built request
   localparam logic [1:0] REQ_FLAGS = 2'b11;

   // Unit scales of the object fields
   localparam logic [15:0] VOLT_50MV_SCALE  = 16'd50;
   localparam logic [15:0] VOLT_100MV_SCALE = 16'd100;
   localparam logic [13:0] CUR_10MA_SCALE   = 14'd10;
   localparam logic [13:0] CUR_50MA_SCALE   = 14'd50;
   localparam logic [17:0] PWR_250MW_SCALE  = 18'd250;

   // Reciprocals for the constant divisions, exact over 16-bit dividends
   // x / 10 = (x * 52429) >> 19
   // x / 20 = (x * 52429) >> 20
   // x / 25 = (x * 83887) >> 21, and x / 50 = (x >> 1) / 25
   localparam int unsigned PROD_W = 33;
   localparam logic [PROD_W-1:0] RECIP_DIV10 = 33'd52429;
   localparam logic [PROD_W-1:0] RECIP_DIV20 = 33'd52429;
   localparam logic [PROD_W-1:0] RECIP_DIV25 = 33'd83887;
   localparam int unsigned SHIFT_DIV10 = 19;
   localparam int unsigned SHIFT_DIV20 = 20;
   localparam int unsigned SHIFT_DIV25 = 21;

   // Saturation limits of the request unit fields
   localparam logic [12:0] FIX_CUR_MAX = 13'h03FF;
   localparam logic [10:0] PPS_CUR_MAX = 11'h07F;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  aug_subtype;
      logic [15:0] volt_hi_mv;
      logic [15:0] volt_lo_mv;
      logic [13:0] max_cur_ma;
      logic [13:0] current_alt_ma;
      logic [17:0] battery_mw;
      logic [7:0]  pdp_watts;
      logic        epr_cap;
   } decode_type;

endpackage

[design/pdrb_req_if.sv]
interface pdrb_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] raw_pdo;
   logic [3:0]  position;
   logic [15:0] request_mv;
   logic [15:0] request_ma;

   modport source (output valid, output raw_pdo, output position, output request_mv,
                   output request_ma, input ready);
   modport sink   (input valid, input raw_pdo, input position, input request_mv,
                   input request_ma, output ready);
endinterface

[design/pdrb_rsp_if.sv]
interface pdrb_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [1:0]  aug_subtype;
   logic [15:0] volt_hi_mv;
   logic [15:0] volt_lo_mv;
   logic [13:0] max_cur_ma;
   logic [13:0] current_alt_ma;
   logic [17:0] battery_mw;
   logic [7:0]  pdp_watts;
   logic        epr_cap;
   logic [31:0] request_word;
   logic        request_ok;

   modport source (output valid, output kind, output aug_subtype, output volt_hi_mv,
                   output volt_lo_mv, output max_cur_ma, output current_alt_ma,
                   output battery_mw, output pdp_watts, output epr_cap,
                   output request_word, output request_ok, input ready);
   modport sink   (input valid, input kind, input aug_subtype, input volt_hi_mv,
                   input volt_lo_mv, input max_cur_ma, input current_alt_ma,
                   input battery_mw, input pdp_watts, input epr_cap,
                   input request_word, input request_ok, output ready);
endinterface

[design/pd_source_pdo_decode_request_build.sv]
// Channel   Direction  Transaction
// req_if    in         raw_pdo, position, request_mv, request_ma
// rsp_if    out        decoded object fields, request_word, request_ok
//
// Three register stages: decode and reciprocal multiplies, quotient
// saturation and PPS range check, request packing into the output register.
// A request passes the stage 1, stage 2 and stage 3 registers in turn before
// rsp_if.valid rises; one transaction per cycle while rsp_if.ready stays high.
// Reset (synchronous, active high) clears the stage valid bits only.
// Each stage loads whenever it is empty or the stage after it moves, so bubbles
// close up; while a result waits on rsp_if.ready the stages behind it still
// fill, then req_if.ready drops.
module pd_source_pdo_decode_request_build (
   input logic        clock,
   input logic        reset,
   pdrb_req_if.sink   req_if,
   pdrb_rsp_if.source rsp_if
);

   localparam int unsigned PW = pdrb_pkg::PROD_W;

   // Stage 1: decode and products
   logic                   s1_valid_ff;
   pdrb_pkg::decode_type   s1_dec_ff, s1_dec_in;
   logic [3:0]             s1_pos_ff;
   logic [15:0]            s1_mv_ff;
   logic [PW-1:0]          s1_ma10_ff, s1_ma10_in;
   logic [PW-1:0]          s1_ma50_ff, s1_ma50_in;
   logic [PW-1:0]          s1_mv20_ff, s1_mv20_in;
   logic [PW-1:0]          s1_mv25_ff, s1_mv25_in;

   // Stage 2: request units
   logic                   s2_valid_ff;
   pdrb_pkg::decode_type   s2_dec_ff;
   logic [3:0]             s2_pos_ff;
   logic [9:0]             s2_cu_fix_ff, s2_cu_fix_in;
   logic [6:0]             s2_cu_pps_ff, s2_cu_pps_in;
   logic [11:0]            s2_vu_pps_ff, s2_vu_pps_in;
   logic [12:0]            s2_vu_avs_ff, s2_vu_avs_in;
   logic                   s2_in_range_ff, s2_in_range_in;

   // Stage 3: output register
   logic                   s3_valid_ff;
   pdrb_pkg::decode_type   s3_dec_ff;
   logic [31:0]            s3_word_ff, s3_word_in;
   logic                   s3_ok_ff, s3_ok_in;

   logic                   s1_ready, s2_ready, s3_ready;

   logic [12:0]            q_ma10;
   logic [10:0]            q_ma50;
   logic [11:0]            q_mv20;
   logic [11:0]            q_mv25;

   // Each stage takes new data when empty or when its contents move on
   assign s3_ready     = !s3_valid_ff || rsp_if.ready;
   assign s2_ready     = !s2_valid_ff || s3_ready;
   assign s1_ready     = !s1_valid_ff || s2_ready;
   assign req_if.ready = s1_ready;

   // Stage 1: decode the object by kind and subtype, start the divisions
   always_comb begin
      s1_dec_in             = '0;
      s1_dec_in.kind        = req_if.raw_pdo[31:30];
      s1_dec_in.aug_subtype = pdrb_pkg::SUB_RESERVED;
      case (req_if.raw_pdo[31:30])
         pdrb_pkg::KIND_FIXED: begin
            s1_dec_in.volt_hi_mv = 16'(req_if.raw_pdo[19:10]) * pdrb_pkg::VOLT_50MV_SCALE;
            s1_dec_in.max_cur_ma = 14'(req_if.raw_pdo[9:0]) * pdrb_pkg::CUR_10MA_SCALE;
            s1_dec_in.epr_cap    = req_if.raw_pdo[17];
         end
         pdrb_pkg::KIND_BATTERY: begin
            s1_dec_in.volt_hi_mv = 16'(req_if.raw_pdo[29:20]) * pdrb_pkg::VOLT_50MV_SCALE;
            s1_dec_in.volt_lo_mv = 16'(req_if.raw_pdo[19:10]) * pdrb_pkg::VOLT_50MV_SCALE;
            s1_dec_in.battery_mw = 18'(req_if.raw_pdo[9:0]) * pdrb_pkg::PWR_250MW_SCALE;
         end
         pdrb_pkg::KIND_VARIABLE: begin
            s1_dec_in.volt_hi_mv = 16'(req_if.raw_pdo[29:20]) * pdrb_pkg::VOLT_50MV_SCALE;
            s1_dec_in.volt_lo_mv = 16'(req_if.raw_pdo[19:10]) * pdrb_pkg::VOLT_50MV_SCALE;
            s1_dec_in.max_cur_ma = 14'(req_if.raw_pdo[9:0]) * pdrb_pkg::CUR_10MA_SCALE;
         end
         default: begin
            s1_dec_in.aug_subtype = req_if.raw_pdo[29:28];
            case (req_if.raw_pdo[29:28])
               pdrb_pkg::SUB_PPS: begin
                  s1_dec_in.max_cur_ma =
                     14'(req_if.raw_pdo[6:0]) * pdrb_pkg::CUR_50MA_SCALE;
                  s1_dec_in.volt_lo_mv =
                     16'(req_if.raw_pdo[15:8]) * pdrb_pkg::VOLT_100MV_SCALE;
                  s1_dec_in.volt_hi_mv =
                     16'(req_if.raw_pdo[24:17]) * pdrb_pkg::VOLT_100MV_SCALE;
               end
               pdrb_pkg::SUB_EPR_AVS: begin
                  s1_dec_in.pdp_watts  = req_if.raw_pdo[7:0];
                  s1_dec_in.volt_lo_mv =
                     16'(req_if.raw_pdo[15:8]) * pdrb_pkg::VOLT_100MV_SCALE;
                  s1_dec_in.volt_hi_mv =
                     16'(req_if.raw_pdo[25:17]) * pdrb_pkg::VOLT_100MV_SCALE;
               end
               pdrb_pkg::SUB_SPR_AVS: begin
                  s1_dec_in.max_cur_ma =
                     14'(req_if.raw_pdo[9:0]) * pdrb_pkg::CUR_10MA_SCALE;
                  s1_dec_in.current_alt_ma =
                     14'(req_if.raw_pdo[19:10]) * pdrb_pkg::CUR_10MA_SCALE;
               end
               default: begin
                  // reserved subtype: only kind and subtype are reported
                  s1_dec_in.aug_subtype = pdrb_pkg::SUB_RESERVED;
               end
            endcase
         end
      endcase
   end

   // Reciprocal multiplies; the shift happens in stage 2
   assign s1_ma10_in = PW'(req_if.request_ma) * pdrb_pkg::RECIP_DIV10;
   assign s1_ma50_in = PW'(req_if.request_ma[15:1]) * pdrb_pkg::RECIP_DIV25;
   assign s1_mv20_in = PW'(req_if.request_mv) * pdrb_pkg::RECIP_DIV20;
   assign s1_mv25_in = PW'(req_if.request_mv) * pdrb_pkg::RECIP_DIV25;

   // Stage 2: quotients, saturation, AVS rounding and PPS window check
   assign q_ma10 = 13'(s1_ma10_ff >> pdrb_pkg::SHIFT_DIV10);
   assign q_ma50 = 11'(s1_ma50_ff >> pdrb_pkg::SHIFT_DIV25);
   assign q_mv20 = 12'(s1_mv20_ff >> pdrb_pkg::SHIFT_DIV20);
   assign q_mv25 = 12'(s1_mv25_ff >> pdrb_pkg::SHIFT_DIV25);

   assign s2_cu_fix_in = (q_ma10 > pdrb_pkg::FIX_CUR_MAX) ? 10'h3FF : q_ma10[9:0];
   assign s2_cu_pps_in = (q_ma50 > pdrb_pkg::PPS_CUR_MAX) ? 7'h7F : q_ma50[6:0];
   // A 16-bit voltage over 20 or 25 stays below the 12- and 13-bit limits
   assign s2_vu_pps_in = q_mv20;
   assign s2_vu_avs_in = {1'b0, q_mv25[11:2], 2'b00};
   assign s2_in_range_in = (s1_mv_ff >= s1_dec_ff.volt_lo_mv) &&
                           (s1_mv_ff <= s1_dec_ff.volt_hi_mv);

   // Stage 3: pack the request word
   always_comb begin
      s3_word_in = '0;
      s3_ok_in   = 1'b0;
      case (s2_dec_ff.kind)
         pdrb_pkg::KIND_FIXED: begin
            s3_word_in = {s2_pos_ff, 2'b00, pdrb_pkg::REQ_FLAGS, 4'b0000,
                          s2_cu_fix_ff, s2_cu_fix_ff};
            s3_ok_in   = 1'b1;
         end
         pdrb_pkg::KIND_AUG: begin
            case (s2_dec_ff.aug_subtype)
               pdrb_pkg::SUB_PPS: begin
                  if (s2_in_range_ff) begin
                     s3_word_in = {s2_pos_ff, 2'b00, pdrb_pkg::REQ_FLAGS, 3'b000,
                                   s2_vu_pps_ff, 2'b00, s2_cu_pps_ff};
                     s3_ok_in   = 1'b1;
                  end
               end
               pdrb_pkg::SUB_EPR_AVS, pdrb_pkg::SUB_SPR_AVS: begin
                  s3_word_in = {s2_pos_ff, 2'b00, pdrb_pkg::REQ_FLAGS, 2'b00,
                                s2_vu_avs_ff, 2'b00, s2_cu_pps_ff};
                  s3_ok_in   = 1'b1;
               end
               default: begin
                  s3_ok_in = 1'b0;
               end
            endcase
         end
         default: begin
            // battery and variable objects build no request
            s3_ok_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_if.valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
         if (s3_ready) s3_valid_ff <= s2_valid_ff;
      end
   end

   // Payload: load whenever the stage advances, no reset
   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_dec_ff  <= s1_dec_in;
         s1_pos_ff  <= req_if.position;
         s1_mv_ff   <= req_if.request_mv;
         s1_ma10_ff <= s1_ma10_in;
         s1_ma50_ff <= s1_ma50_in;
         s1_mv20_ff <= s1_mv20_in;
         s1_mv25_ff <= s1_mv25_in;
      end
      if (s2_ready) begin
         s2_dec_ff      <= s1_dec_ff;
         s2_pos_ff      <= s1_pos_ff;
         s2_cu_fix_ff   <= s2_cu_fix_in;
         s2_cu_pps_ff   <= s2_cu_pps_in;
         s2_vu_pps_ff   <= s2_vu_pps_in;
         s2_vu_avs_ff   <= s2_vu_avs_in;
         s2_in_range_ff <= s2_in_range_in;
      end
      if (s3_ready) begin
         s3_dec_ff  <= s2_dec_ff;
         s3_word_ff <= s3_word_in;
         s3_ok_ff   <= s3_ok_in;
      end
   end

   assign rsp_if.valid          = s3_valid_ff;
   assign rsp_if.kind           = s3_dec_ff.kind;
   assign rsp_if.aug_subtype    = s3_dec_ff.aug_subtype;
   assign rsp_if.volt_hi_mv     = s3_dec_ff.volt_hi_mv;
   assign rsp_if.volt_lo_mv     = s3_dec_ff.volt_lo_mv;
   assign rsp_if.max_cur_ma     = s3_dec_ff.max_cur_ma;
   assign rsp_if.current_alt_ma = s3_dec_ff.current_alt_ma;
   assign rsp_if.battery_mw     = s3_dec_ff.battery_mw;
   assign rsp_if.pdp_watts      = s3_dec_ff.pdp_watts;
   assign rsp_if.epr_cap        = s3_dec_ff.epr_cap;
   assign rsp_if.request_word   = s3_word_ff;
   assign rsp_if.request_ok     = s3_ok_ff;

endmodule

[tb/pd_source_pdo_decode_request_build_test.sv]
module pd_source_pdo_decode_request_build_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Give up well past the slowest legal run (about a thousand transactions)
   localparam int unsigned CYCLE_LIMIT = 100000;
   // Idle percentage of each side outside the steady stretch
   localparam int unsigned IDLE_PCT = 28;
   // Cycles to watch for stray results after the last expectation is met
   localparam int unsigned SETTLE_CYCLES = 8;

   // One request transaction: object word, its position, requested mV and mA
   typedef struct packed {
      logic [31:0] raw_pdo;
      logic [3:0]  position;
      logic [15:0] request_mv;
      logic [15:0] request_ma;
   } pdo_request_type;

   // One response transaction: decoded object plus the built request word
   typedef struct packed {
      pdrb_pkg::decode_type fields;
      logic [31:0]          request_word;
      logic                 request_ok;
   } pdo_response_type;

   logic clock = 1'b0;
   logic reset;

   pdrb_req_if req_if();
   pdrb_rsp_if rsp_if();

   pd_source_pdo_decode_request_build u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Responses still owed by the block, oldest first
   pdo_response_type pending_responses[$];

   bit          steady_flow = 1'b0;
   int unsigned error_count = 0;
   int unsigned cycle_count = 0;
   int unsigned responses_checked = 0;
   int unsigned requests_built = 0;
   int unsigned pps_refused = 0;
   int unsigned kind_count[4] = '{0, 0, 0, 0};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Decode the object and build the request word it allows.
   // Fields that do not apply to the kind stay zero; the subtype reads
   // reserved for any object that is not augmented.
   function automatic pdo_response_type predict_response(pdo_request_type item);
      pdo_response_type resp;
      logic [31:0]      head;
      int unsigned      cur_units;
      int unsigned      volt_units;
      begin
         resp = '0;
         resp.fields.kind = item.raw_pdo[31:30];
         resp.fields.aug_subtype = pdrb_pkg::SUB_RESERVED;
         head = {item.position, 2'b00, pdrb_pkg::REQ_FLAGS, 24'd0};
         case (resp.fields.kind)
            pdrb_pkg::KIND_FIXED: begin
               resp.fields.volt_hi_mv = 16'(item.raw_pdo[19:10] * 50);
               resp.fields.max_cur_ma = 14'(item.raw_pdo[9:0] * 10);
               resp.fields.epr_cap = item.raw_pdo[17];
               // operating and max current both in 10 mA units, 10 bits
               cur_units = item.request_ma / 10;
               if (cur_units > 'h3FF) cur_units = 'h3FF;
               resp.request_word = head | (cur_units << 10) | cur_units;
               resp.request_ok = 1'b1;
            end
            pdrb_pkg::KIND_BATTERY: begin
               resp.fields.volt_hi_mv = 16'(item.raw_pdo[29:20] * 50);
               resp.fields.volt_lo_mv = 16'(item.raw_pdo[19:10] * 50);
               resp.fields.battery_mw = 18'(item.raw_pdo[9:0] * 250);
            end
            pdrb_pkg::KIND_VARIABLE: begin
               resp.fields.volt_hi_mv = 16'(item.raw_pdo[29:20] * 50);
               resp.fields.volt_lo_mv = 16'(item.raw_pdo[19:10] * 50);
               resp.fields.max_cur_ma = 14'(item.raw_pdo[9:0] * 10);
            end
            default: begin
               resp.fields.aug_subtype = item.raw_pdo[29:28];
               // PPS and AVS share the 50 mA, 7-bit current field
               cur_units = item.request_ma / 50;
               if (cur_units > 'h7F) cur_units = 'h7F;
               case (resp.fields.aug_subtype)
                  pdrb_pkg::SUB_PPS: begin
                     resp.fields.max_cur_ma = 14'(item.raw_pdo[6:0] * 50);
                     resp.fields.volt_lo_mv = 16'(item.raw_pdo[15:8] * 100);
                     resp.fields.volt_hi_mv = 16'(item.raw_pdo[24:17] * 100);
                     // refuse a voltage outside the programmable range
                     if (item.request_mv >= resp.fields.volt_lo_mv &&
                         item.request_mv <= resp.fields.volt_hi_mv) begin
                        volt_units = item.request_mv / 20;
                        if (volt_units > 'hFFF) volt_units = 'hFFF;
                        resp.request_word = head | (volt_units << 9) | cur_units;
                        resp.request_ok = 1'b1;
                     end
                  end
                  pdrb_pkg::SUB_SPR_AVS, pdrb_pkg::SUB_EPR_AVS: begin
                     if (resp.fields.aug_subtype == pdrb_pkg::SUB_SPR_AVS) begin
                        resp.fields.max_cur_ma = 14'(item.raw_pdo[9:0] * 10);
                        resp.fields.current_alt_ma = 14'(item.raw_pdo[19:10] * 10);
                     end else begin
                        resp.fields.pdp_watts = item.raw_pdo[7:0];
                        resp.fields.volt_lo_mv = 16'(item.raw_pdo[15:8] * 100);
                        resp.fields.volt_hi_mv = 16'(item.raw_pdo[25:17] * 100);
                     end
                     // 25 mV units, truncated to a 100 mV step, no range check
                     volt_units = item.request_mv / 25;
                     if (volt_units > 'h1FFF) volt_units = 'h1FFF;
                     volt_units = volt_units & ~32'h3;
                     resp.request_word = head | (volt_units << 9) | cur_units;
                     resp.request_ok = 1'b1;
                  end
                  default: ;
               endcase
            end
         endcase
         return resp;
      end
   endfunction

   // Random object of the given kind and subtype, with the request voltage
   // steered toward the PPS range edges and the current toward saturation.
   function automatic pdo_request_type random_object(logic [1:0] kind, logic [1:0] sub);
      pdo_request_type item;
      int unsigned     lo_mv;
      int unsigned     hi_mv;
      begin
         item.raw_pdo = $urandom;
         item.raw_pdo[31:30] = kind;
         if (kind == pdrb_pkg::KIND_AUG) item.raw_pdo[29:28] = sub;
         item.position = 4'($urandom_range(15));
         item.request_mv = 16'($urandom);
         case ($urandom_range(7))
            0: item.request_ma = 16'h0000;
            1: item.request_ma = 16'hFFFF;
            2: item.request_ma = 16'($urandom_range(10250, 10220));
            3: item.request_ma = 16'($urandom_range(6420, 6330));
            default: item.request_ma = 16'($urandom_range(16'hFFFF));
         endcase
         if (kind == pdrb_pkg::KIND_AUG && sub == pdrb_pkg::SUB_PPS) begin
            // mostly keep the range non-empty so most requests get built
            if ($urandom_range(4) != 0 && item.raw_pdo[15:8] > item.raw_pdo[24:17])
               {item.raw_pdo[24:17], item.raw_pdo[15:8]} =
                  {item.raw_pdo[15:8], item.raw_pdo[24:17]};
            lo_mv = item.raw_pdo[15:8] * 100;
            hi_mv = item.raw_pdo[24:17] * 100;
            case ($urandom_range(9))
               0: item.request_mv = 16'(lo_mv);
               1: item.request_mv = 16'(hi_mv);
               2: item.request_mv = 16'(lo_mv - 1);
               3: item.request_mv = 16'(hi_mv + 1);
               4: ;
               default:
                  if (lo_mv <= hi_mv) item.request_mv = 16'($urandom_range(hi_mv, lo_mv));
            endcase
         end
         return item;
      end
   endfunction

   task automatic report_error(string msg);
      begin
         $display("[%0t] mismatch: %s", $realtime, msg);
         error_count++;
      end
   endtask

   task automatic compare_field(string name, logic [31:0] got, logic [31:0] want);
      begin
         if (got !== want)
            report_error($sformatf("response %0d %s got 0x%0h want 0x%0h",
                                   responses_checked, name, got, want));
      end
   endtask

   // Present one transaction, hold it until accepted, then log its response.
   // Ends on the accepting edge with valid still high.
   task automatic send_object(pdo_request_type item);
      begin
         if (!steady_flow) begin
            while ($urandom_range(99) < IDLE_PCT) begin
               req_if.valid <= 1'b0;
               @(posedge clock);
            end
         end
         req_if.valid      <= 1'b1;
         req_if.raw_pdo    <= item.raw_pdo;
         req_if.position   <= item.position;
         req_if.request_mv <= item.request_mv;
         req_if.request_ma <= item.request_ma;
         @(posedge clock);
         while (!req_if.ready) @(posedge clock);
         pending_responses.push_back(predict_response(item));
         kind_count[item.raw_pdo[31:30]]++;
      end
   endtask

   // Drop valid and hold off until every owed response has come back
   task automatic wait_for_responses();
      begin
         req_if.valid <= 1'b0;
         @(posedge clock);
         while (pending_responses.size() != 0) @(posedge clock);
      end
   endtask

   task automatic test_directed_corners();
      begin
         // fixed: all-zero, all-ones with EPR flag, current at and past saturation
         send_object('{32'h0000_0000, 4'd0,  16'd0,     16'd0});
         send_object('{32'h3FFF_FFFF, 4'd15, 16'hFFFF,  16'hFFFF});
         send_object('{32'h0002_D12C, 4'd1,  16'd5000,  16'd10239});
         send_object('{32'h0001_912C, 4'd7,  16'd0,     16'd10240});
         // battery and variable: both field extremes, no request
         send_object('{32'h7FFF_FFFF, 4'd2,  16'hFFFF,  16'hFFFF});
         send_object('{32'h4000_0000, 4'd3,  16'd5000,  16'd1000});
         send_object('{32'hBFFF_FFFF, 4'd4,  16'hFFFF,  16'hFFFF});
         send_object('{32'h8000_0000, 4'd5,  16'd0,     16'd0});
         // PPS 3.3 to 11 V: both range edges accepted, one step outside refused
         send_object('{32'hC0DC_213C, 4'd6,  16'd3300,  16'd3000});
         send_object('{32'hC0DC_213C, 4'd8,  16'd11000, 16'd6399});
         send_object('{32'hC0DC_213C, 4'd9,  16'd3299,  16'd3000});
         send_object('{32'hC0DC_213C, 4'd10, 16'd11001, 16'd3000});
         // PPS all-ones fields, current past saturation
         send_object('{32'hCFFF_FFFF, 4'd11, 16'd25500, 16'd6400});
         // PPS empty range (minimum above maximum) and zero range
         send_object('{32'hC002_0500, 4'd12, 16'd300,   16'd500});
         send_object('{32'hC000_0000, 4'd13, 16'd0,     16'd0});
         // EPR AVS: extremes and a voltage that rounds down
         send_object('{32'hDFFF_FFFF, 4'd14, 16'hFFFF,  16'hFFFF});
         send_object('{32'hD000_0000, 4'd0,  16'd0,     16'd0});
         send_object('{32'hD2A8_3C8C, 4'd5,  16'd15099, 16'd2549});
         // SPR AVS extremes
         send_object('{32'hEFFF_FFFF, 4'd15, 16'hFFFF,  16'hFFFF});
         send_object('{32'hE000_0000, 4'd1,  16'd9000,  16'd3000});
         // reserved augmented subtype, no request
         send_object('{32'hF000_0000, 4'd2,  16'd1000,  16'd1000});
         send_object('{32'hFFFF_FFFF, 4'd15, 16'hFFFF,  16'hFFFF});
         wait_for_responses();
      end
   endtask

   task automatic test_fixed_requests();
      begin
         repeat (150)
            send_object(random_object(pdrb_pkg::KIND_FIXED, pdrb_pkg::SUB_RESERVED));
         wait_for_responses();
      end
   endtask

   task automatic test_legacy_objects();
      begin
         repeat (100)
            send_object(random_object($urandom_range(1) ? pdrb_pkg::KIND_BATTERY
                                                        : pdrb_pkg::KIND_VARIABLE,
                                      pdrb_pkg::SUB_RESERVED));
         wait_for_responses();
      end
   endtask

   task automatic test_pps_requests();
      begin
         repeat (250) send_object(random_object(pdrb_pkg::KIND_AUG, pdrb_pkg::SUB_PPS));
         wait_for_responses();
      end
   endtask

   task automatic test_avs_requests();
      begin
         repeat (200)
            send_object(random_object(pdrb_pkg::KIND_AUG,
                                      $urandom_range(1) ? pdrb_pkg::SUB_SPR_AVS
                                                        : pdrb_pkg::SUB_EPR_AVS));
         wait_for_responses();
      end
   endtask

   // Every kind and subtype mixed; a stretch at full rate on both sides,
   // and one pause mid-stream until the pipeline has emptied
   task automatic test_mixed_traffic();
      int unsigned n;
      begin
         for (n = 0; n < 230; n++) begin
            steady_flow = (n >= 60 && n < 160);
            if (n == 180) wait_for_responses();
            send_object(random_object(2'($urandom_range(3)), 2'($urandom_range(3))));
         end
         steady_flow = 1'b0;
         wait_for_responses();
      end
   endtask

   // Response side: random back-pressure, check each accepted transaction
   // against the oldest owed response
   always @(posedge clock) begin
      pdo_response_type got;
      pdo_response_type want;
      rsp_if.ready <= steady_flow || ($urandom_range(99) >= IDLE_PCT);
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         got.fields.kind           = rsp_if.kind;
         got.fields.aug_subtype    = rsp_if.aug_subtype;
         got.fields.volt_hi_mv     = rsp_if.volt_hi_mv;
         got.fields.volt_lo_mv     = rsp_if.volt_lo_mv;
         got.fields.max_cur_ma     = rsp_if.max_cur_ma;
         got.fields.current_alt_ma = rsp_if.current_alt_ma;
         got.fields.battery_mw     = rsp_if.battery_mw;
         got.fields.pdp_watts      = rsp_if.pdp_watts;
         got.fields.epr_cap        = rsp_if.epr_cap;
         got.request_word          = rsp_if.request_word;
         got.request_ok            = rsp_if.request_ok;
         if (pending_responses.size() == 0) begin
            report_error($sformatf("response with nothing owed, request_word 0x%0h",
                                   got.request_word));
         end else begin
            want = pending_responses.pop_front();
            compare_field("kind", 32'(got.fields.kind), 32'(want.fields.kind));
            compare_field("aug_subtype", 32'(got.fields.aug_subtype),
                          32'(want.fields.aug_subtype));
            compare_field("volt_hi_mv", 32'(got.fields.volt_hi_mv),
                          32'(want.fields.volt_hi_mv));
            compare_field("volt_lo_mv", 32'(got.fields.volt_lo_mv),
                          32'(want.fields.volt_lo_mv));
            compare_field("max_cur_ma", 32'(got.fields.max_cur_ma),
                          32'(want.fields.max_cur_ma));
            compare_field("current_alt_ma", 32'(got.fields.current_alt_ma),
                          32'(want.fields.current_alt_ma));
            compare_field("battery_mw", 32'(got.fields.battery_mw),
                          32'(want.fields.battery_mw));
            compare_field("pdp_watts", 32'(got.fields.pdp_watts),
                          32'(want.fields.pdp_watts));
            compare_field("epr_cap", 32'(got.fields.epr_cap), 32'(want.fields.epr_cap));
            compare_field("request_word", got.request_word, want.request_word);
            compare_field("request_ok", 32'(got.request_ok), 32'(want.request_ok));
            if (want.request_ok) requests_built++;
            if (want.fields.kind == pdrb_pkg::KIND_AUG &&
                want.fields.aug_subtype == pdrb_pkg::SUB_PPS && !want.request_ok)
               pps_refused++;
            responses_checked++;
         end
      end
   end

   // Watchdog: a stuck handshake or a lost response ends the run here
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still owed",
                  cycle_count, pending_responses.size());
         $display("pd_source_pdo_decode_request_build_test: errors");
         $finish;
      end
   end

   initial begin
      // drive every request input to a known value from time zero
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.raw_pdo    <= '0;
      req_if.position   <= '0;
      req_if.request_mv <= '0;
      req_if.request_ma <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_fixed_requests();
      test_legacy_objects();
      test_pps_requests();
      test_avs_requests();
      test_mixed_traffic();

      // watch for stray responses before printing the summary
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("objects: %0d fixed, %0d battery, %0d variable, %0d augmented",
               kind_count[pdrb_pkg::KIND_FIXED], kind_count[pdrb_pkg::KIND_BATTERY],
               kind_count[pdrb_pkg::KIND_VARIABLE], kind_count[pdrb_pkg::KIND_AUG]);
      $display("%0d responses checked, %0d requests built, %0d PPS requests refused",
               responses_checked, requests_built, pps_refused);
      if (error_count == 0) begin
         $display("pd_source_pdo_decode_request_build_test: clean");
      end else begin
         $display("pd_source_pdo_decode_request_build_test: errors");
      end
      $finish;
   end

endmodule
